/* rtl/bitmap_scanline_shifter_core_assert.svh */
// Assertion macros for the bitmap scanline shifter.
// Included by bss_out_stage, the RTL module that checks its own logic; no other dependencies.
`ifndef BITMAP_SCANLINE_SHIFTER_CORE_ASSERT_SVH
`define BITMAP_SCANLINE_SHIFTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define BSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BSS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `BSS_ASSERT(label, clk, rst_n, !(expr), msg)

`else

`define BSS_ASSERT(label, clk, rst_n, prop, msg)

`define BSS_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/bss_pkg.sv */
// Package for the bitmap scanline shifter: field widths, register indexes, shared types.
// No dependencies.
package bss_pkg;

    localparam int WORD_BITS = 32;
    localparam int SHIFT_W   = 5;
    localparam int DIM_W     = 13;
    localparam int LINE_W    = 12;
    localparam int IDX_W     = 7;
    localparam int WORDS_W   = 9;
    localparam int SKIP_W    = 8;

    localparam logic [1:0] REG_SHIFT_X      = 2'd0;
    localparam logic [1:0] REG_SHIFT_Y      = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0]   fh;
        logic [WORDS_W-1:0] words;
        logic               x_neg;
        logic [SKIP_W-1:0]  skip;
        logic [SHIFT_W-1:0] bit_shift;
        logic [DIM_W-1:0]   shift_y;
        logic               shift_ok;
    } cfg_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] cur;
        logic [WORD_BITS-1:0] prev;
        logic [LINE_W-1:0]    line;
        logic [IDX_W-1:0]     idx;
    } item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [LINE_W-1:0]    line;
        logic [IDX_W-1:0]     idx;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } pair_t;

endpackage

/* rtl/bss_cfg.sv */
// Configuration registers and values derived from them (clamped frame size, word split of shift).
// Depends on bss_pkg.
module bss_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [bss_pkg::DIM_W-1:0]   cfg_wdata,
    output bss_pkg::cfg_t               cfg
);
    import bss_pkg::*;

    logic [DIM_W-1:0] shift_x_reg;
    logic [DIM_W-1:0] shift_y_reg;
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;

    logic [DIM_W-1:0]   fw;
    logic [DIM_W-1:0]   fh;
    logic [DIM_W:0]     words_sum;
    logic [DIM_W-1:0]   x_mag;
    logic [DIM_W-1:0]   y_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_x_reg      <= '0;
            shift_y_reg      <= '0;
            frame_width_reg  <= DIM_W'(4096);
            frame_height_reg <= DIM_W'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHIFT_X:      shift_x_reg      <= cfg_wdata;
                REG_SHIFT_Y:      shift_y_reg      <= cfg_wdata;
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg == '0)
            fw = DIM_W'(1);
        else if ({19'b0, frame_width_reg} > 32'(MAX_WIDTH))
            fw = DIM_W'(MAX_WIDTH);
        else
            fw = frame_width_reg;

        if (frame_height_reg == '0)
            fh = DIM_W'(1);
        else if ({19'b0, frame_height_reg} > 32'(MAX_HEIGHT))
            fh = DIM_W'(MAX_HEIGHT);
        else
            fh = frame_height_reg;

        words_sum = {1'b0, fw} + (DIM_W+1)'(WORD_BITS - 1);
        x_mag = shift_x_reg[DIM_W-1] ? (~shift_x_reg + DIM_W'(1)) : shift_x_reg;
        y_mag = shift_y_reg[DIM_W-1] ? (~shift_y_reg + DIM_W'(1)) : shift_y_reg;

        cfg.fh        = fh;
        cfg.words     = words_sum[DIM_W:SHIFT_W];
        cfg.x_neg     = shift_x_reg[DIM_W-1];
        cfg.skip      = x_mag[DIM_W-1:SHIFT_W];
        cfg.bit_shift = x_mag[SHIFT_W-1:0];
        cfg.shift_y   = shift_y_reg;
        cfg.shift_ok  = (x_mag < fw) && (y_mag < fh);
    end

endmodule

/* rtl/bss_in_stage.sv */
// Input register and prior-word state; drops words outside the frame at acceptance.
// Depends on bss_pkg.
module bss_in_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            src_valid,
    output logic                            src_stall,
    input  logic [bss_pkg::WORD_BITS-1:0]   src_word,
    input  logic [bss_pkg::LINE_W-1:0]      src_line,
    input  logic [bss_pkg::IDX_W-1:0]       src_word_index,
    input  bss_pkg::cfg_t                   cfg,
    input  logic                            advance,
    output logic                            item_valid,
    output bss_pkg::item_t                  item
);
    import bss_pkg::*;

    logic                 item_valid_reg;
    logic                 item_valid_next;
    item_t                item_reg;
    logic [WORD_BITS-1:0] prior_word_reg;
    logic                 accept;
    logic                 in_range;

    assign src_stall = item_valid_reg && !advance;
    assign accept    = src_valid && !src_stall;
    assign in_range  = ({2'b0, src_word_index} < cfg.words)
                    && ({1'b0, src_line} < cfg.fh);

    always_comb
    begin
        if (accept)
            item_valid_next = in_range;
        else if (advance)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            prior_word_reg <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (accept && in_range)
                prior_word_reg <= src_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            item_reg.cur  <= src_word;
            item_reg.prev <= (src_word_index == '0) ? '0 : prior_word_reg;
            item_reg.line <= src_line;
            item_reg.idx  <= src_word_index;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/bss_compute.sv */
// Funnel shift and destination addressing for one registered item; up to two results.
// Depends on bss_pkg.
module bss_compute (
    input  bss_pkg::cfg_t   cfg,
    input  bss_pkg::item_t  item,
    output bss_pkg::pair_t  pair
);
    import bss_pkg::*;

    logic [DIM_W:0]       dl;
    logic                 dl_ok;
    logic [WORDS_W-1:0]   idx9;
    logic [WORDS_W-1:0]   skip9;
    logic [WORDS_W-1:0]   sum9;
    logic [SHIFT_W:0]     inv_shift;
    logic                 l_zero;
    logic                 a_ok;
    logic                 b_ok;
    res_t                 ra;
    res_t                 rb;

    always_comb
    begin
        dl        = {2'b0, item.line} + {cfg.shift_y[DIM_W-1], cfg.shift_y};
        dl_ok     = !dl[DIM_W] && (dl[DIM_W-1:0] < cfg.fh) && cfg.shift_ok;
        idx9      = {2'b0, item.idx};
        skip9     = {1'b0, cfg.skip};
        sum9      = idx9 + skip9;
        inv_shift = (SHIFT_W+1)'(WORD_BITS) - {1'b0, cfg.bit_shift};
        l_zero    = (cfg.bit_shift == '0);

        ra.line = dl[LINE_W-1:0];
        rb.line = dl[LINE_W-1:0];
        ra.last = 1'b0;
        rb.last = 1'b1;
        rb.word = item.cur >> cfg.bit_shift;
        rb.idx  = IDX_W'(cfg.words - WORDS_W'(1) - skip9);
        b_ok    = 1'b0;

        if (!cfg.x_neg)
        begin
            a_ok    = sum9 < cfg.words;
            ra.idx  = sum9[IDX_W-1:0];
            ra.word = l_zero ? item.cur
                             : ((item.cur << cfg.bit_shift) | (item.prev >> inv_shift));
        end
        else if (l_zero)
        begin
            a_ok    = idx9 >= skip9;
            ra.idx  = IDX_W'(idx9 - skip9);
            ra.word = item.cur;
        end
        else
        begin
            a_ok    = idx9 > skip9;
            ra.idx  = IDX_W'(idx9 - skip9 - WORDS_W'(1));
            ra.word = (item.prev >> cfg.bit_shift) | (item.cur << inv_shift);
            b_ok    = idx9 == (cfg.words - WORDS_W'(1));
        end

        a_ok = a_ok && dl_ok;
        b_ok = b_ok && dl_ok;

        // last flag sits on whichever result comes out last
        pair.r1 = rb;
        if (a_ok)
        begin
            pair.r0      = ra;
            pair.r0.last = !b_ok;
            pair.count   = b_ok ? 2'd2 : 2'd1;
        end
        else
        begin
            pair.r0    = rb;
            pair.count = b_ok ? 2'd1 : 2'd0;
        end
    end

endmodule

/* rtl/bss_out_stage.sv */
// Two-slot result register; the second slot holds the extra line-end word.
// Depends on bss_pkg and bitmap_scanline_shifter_core_assert.svh.
module bss_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  bss_pkg::pair_t                  pair,
    output logic                            load_ok,
    output logic                            dst_valid,
    input  logic                            dst_stall,
    output logic [bss_pkg::WORD_BITS-1:0]   dst_word,
    output logic [bss_pkg::LINE_W-1:0]      dst_line,
    output logic [bss_pkg::IDX_W-1:0]       dst_word_index,
    output logic                            run_last
);
    import bss_pkg::*;

    `include "bitmap_scanline_shifter_core_assert.svh"

    logic [1:0] count_reg;
    logic [1:0] count_next;
    res_t       slot0_reg;
    res_t       slot1_reg;
    logic       take;
    logic       load;

    assign take    = (count_reg != 2'd0) && !dst_stall;
    assign load_ok = (count_reg == 2'd0) || ((count_reg == 2'd1) && take);
    assign load    = item_valid && load_ok;

    always_comb
    begin
        if (load)
            count_next = pair.count;
        else if (take)
            count_next = count_reg - 2'd1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= pair.r0;
            slot1_reg <= pair.r1;
        end
        else if (take)
            slot0_reg <= slot1_reg;
    end

    assign dst_valid      = (count_reg != 2'd0);
    assign dst_word       = slot0_reg.word;
    assign dst_line       = slot0_reg.line;
    assign dst_word_index = slot0_reg.idx;
    assign run_last       = slot0_reg.last;

    `BSS_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg == 2'd3, "result count out of range")
    `BSS_ASSERT_NEVER(a_first_not_last, clk, rst_n, (count_reg == 2'd2) && slot0_reg.last, "first of two results marked last")
    `BSS_ASSERT(a_second_last, clk, rst_n, (count_reg == 2'd2) |-> slot1_reg.last, "second result not marked last")
    `BSS_ASSERT(a_shift_slot, clk, rst_n, ((count_reg == 2'd2) && take) |=> ((count_reg == 2'd1) && (slot0_reg == $past(slot1_reg))), "second result lost on shift")

endmodule

/* rtl/bitmap_scanline_shifter_core.sv */
// Top level of the bitmap scanline shifter: 1-bpp funnel shift blit by signed x/y offsets.
// Depends on bss_pkg, bss_cfg, bss_in_stage, bss_compute, bss_out_stage.
//
//   channel  handshake              payload
//   src      src_valid / src_stall  src_word, src_line, src_word_index
//   dst      dst_valid / dst_stall  dst_word, dst_line, dst_word_index, run_last
//   cfg      cfg_we                 cfg_index, cfg_wdata
//
// One item per cycle when nothing stalls; an accepted item passes the input register and then
// the result register. A line-end word with a negative non-word-aligned x shift can give
// two results, which the two-slot output drains one after the other.
// rst_n clears config to defaults, prior word to zero and all valid state.
// dst_stall back-pressures through the result slots to src_stall in the same cycle.
module bitmap_scanline_shifter_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [bss_pkg::DIM_W-1:0]       cfg_wdata,
    input  logic                            src_valid,
    output logic                            src_stall,
    input  logic [bss_pkg::WORD_BITS-1:0]   src_word,
    input  logic [bss_pkg::LINE_W-1:0]      src_line,
    input  logic [bss_pkg::IDX_W-1:0]       src_word_index,
    output logic                            dst_valid,
    input  logic                            dst_stall,
    output logic [bss_pkg::WORD_BITS-1:0]   dst_word,
    output logic [bss_pkg::LINE_W-1:0]      dst_line,
    output logic [bss_pkg::IDX_W-1:0]       dst_word_index,
    output logic                            run_last
);
    import bss_pkg::*;

    cfg_t  cfg;
    item_t item;
    pair_t pair;
    logic  item_valid;
    logic  load_ok;

    bss_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bss_in_stage u_in (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .src_word       (src_word),
        .src_line       (src_line),
        .src_word_index (src_word_index),
        .cfg            (cfg),
        .advance        (load_ok),
        .item_valid     (item_valid),
        .item           (item)
    );

    bss_compute u_compute (
        .cfg  (cfg),
        .item (item),
        .pair (pair)
    );

    bss_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .pair           (pair),
        .load_ok        (load_ok),
        .dst_valid      (dst_valid),
        .dst_stall      (dst_stall),
        .dst_word       (dst_word),
        .dst_line       (dst_line),
        .dst_word_index (dst_word_index),
        .run_last       (run_last)
    );

endmodule

/* tb/bitmap_scanline_shifter_core_tb.sv */
// Self-checking testbench for bitmap_scanline_shifter_core: streams bitmap words through
// a range of shift and frame settings and checks each shifted word against its own model.
// Depends on bss_pkg and the shifter core RTL.
module bitmap_scanline_shifter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;

    localparam int MAX_WIDTH       = 4096;
    localparam int MAX_HEIGHT      = 4096;
    localparam int QUIET_LIMIT     = 2000;
    localparam int PRESSURE_CYCLES = 300;
    localparam int NUM_PHASES      = 13;
    localparam int PHASE_ITEMS     = 141;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [LINE_W-1:0]    line;
        logic [IDX_W-1:0]     idx;
    } src_item_t;

    typedef struct {
        res_t            r;
        longint unsigned at;
    } awaited_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = REG_SHIFT_X;
    logic [DIM_W-1:0]     cfg_wdata = '0;
    logic                 src_valid = 1'b0;
    logic                 src_stall;
    logic [WORD_BITS-1:0] src_word = '0;
    logic [LINE_W-1:0]    src_line = '0;
    logic [IDX_W-1:0]     src_word_index = '0;
    logic                 dst_valid;
    logic                 dst_stall = 1'b0;
    logic [WORD_BITS-1:0] dst_word;
    logic [LINE_W-1:0]    dst_line;
    logic [IDX_W-1:0]     dst_word_index;
    logic                 run_last;

    // shadow copy of the block's registers and line state
    logic [DIM_W-1:0]     shift_x_q = '0;
    logic [DIM_W-1:0]     shift_y_q = '0;
    logic [DIM_W-1:0]     frame_width_q = 13'd4096;
    logic [DIM_W-1:0]     frame_height_q = 13'd4096;
    logic [WORD_BITS-1:0] prior_word_q = '0;

    src_item_t src_backlog[$];
    awaited_t  awaited_words[$];

    int src_gap = 0;
    int dst_hold = 0;
    int src_idle_pct = 15;
    int dst_idle_pct = 15;
    int results_seen = 0;
    int err_count = 0;
    int quiet_cycles = 0;
    bit pressure_done = 1'b0;

    // sx, sy, frame width, frame height
    int phase_cfg [NUM_PHASES][4] = '{
        '{0, 0, 4096, 4096},
        '{-37, 5, 100, 20},
        '{45, 2, 300, 50},
        '{-64, -3, 200, 16},
        '{-1, -1, 33, 8},
        '{4095, -4095, 4096, 4096},
        '{-4095, 4095, 4096, 4096},
        '{0, 0, 0, 0},
        '{31, 1, 8191, 8191},
        '{-33, 0, 96, 4096},
        '{100, -7, 4095, 12},
        '{500, 0, 400, 10},
        '{-70, 2, 4096, 4096}
    };

    bitmap_scanline_shifter_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .src_word       (src_word),
        .src_line       (src_line),
        .src_word_index (src_word_index),
        .dst_valid      (dst_valid),
        .dst_stall      (dst_stall),
        .dst_word       (dst_word),
        .dst_line       (dst_line),
        .dst_word_index (dst_word_index),
        .run_last       (run_last)
    );

    always #1 clk = ~clk;

    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int limit);
        int d;
        d = int'(v);
        if (d < 1)
            d = 1;
        if (d > limit)
            d = limit;
        return d;
    endfunction

    function automatic void predict_shift(input logic [WORD_BITS-1:0] cur,
                                          input logic [LINE_W-1:0] line,
                                          input logic [IDX_W-1:0] idx);
        int fw, fh, words, sx, sy, dl, mag, s, l, n, i, k;
        logic [WORD_BITS-1:0] prev;
        res_t outs [2];
        awaited_t a;
        fw = eff_dim(frame_width_q, MAX_WIDTH);
        fh = eff_dim(frame_height_q, MAX_HEIGHT);
        words = (fw + WORD_BITS - 1) / WORD_BITS;
        i = int'(idx);
        n = 0;
        if (i >= words || int'(line) >= fh)
            return;
        prev = (i == 0) ? '0 : prior_word_q;
        prior_word_q = cur;
        sx = int'($signed(shift_x_q));
        sy = int'($signed(shift_y_q));
        if (sx <= -fw || sx >= fw || sy <= -fh || sy >= fh)
            return;
        dl = int'(line) + sy;
        if (dl < 0 || dl >= fh)
            return;
        mag = (sx < 0) ? -sx : sx;
        s = mag / WORD_BITS;
        l = mag % WORD_BITS;
        if (sx >= 0)
        begin
            if (i + s < words)
            begin
                outs[n].word = cur << l;
                if (l != 0)
                    outs[n].word = outs[n].word | (prev >> (WORD_BITS - l));
                outs[n].idx = IDX_W'(i + s);
                n++;
            end
        end
        else if (l == 0)
        begin
            if (i >= s)
            begin
                outs[n].word = cur;
                outs[n].idx = IDX_W'(i - s);
                n++;
            end
        end
        else
        begin
            if (i >= s + 1)
            begin
                outs[n].word = (prev >> l) | (cur << (WORD_BITS - l));
                outs[n].idx = IDX_W'(i - s - 1);
                n++;
            end
            // line end also flushes the tail word
            if (i == words - 1)
            begin
                outs[n].word = cur >> l;
                outs[n].idx = IDX_W'(words - 1 - s);
                n++;
            end
        end
        for (k = 0; k < n; k++)
        begin
            outs[k].line = LINE_W'(dl);
            outs[k].last = (k == n - 1);
            a.r = outs[k];
            a.at = $time;
            awaited_words = {awaited_words, a};
        end
    endfunction

    function automatic void push_item(input logic [WORD_BITS-1:0] word, input int line,
                                      input int idx);
        src_item_t it;
        it.word = word;
        it.line = LINE_W'(line);
        it.idx = IDX_W'(idx);
        src_backlog = {src_backlog, it};
    endfunction

    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic drain();
        do
            @(negedge clk);
        while (src_backlog.size() != 0 || src_valid || awaited_words.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] index, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value[DIM_W-1:0];
        case (index)
            REG_SHIFT_X:      shift_x_q = value[DIM_W-1:0];
            REG_SHIFT_Y:      shift_y_q = value[DIM_W-1:0];
            REG_FRAME_WIDTH:  frame_width_q = value[DIM_W-1:0];
            REG_FRAME_HEIGHT: frame_height_q = value[DIM_W-1:0];
        endcase
    endtask

    task automatic configure(input int sx, input int sy, input int fw, input int fh);
        drain();
        // items that give no result may still be in flight
        repeat (8) @(negedge clk);
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // mostly whole lines in order, some cut short, some stray words
    task automatic fill_random(input int count);
        int fw, fh, words, sy, lo, hi, line, len, kind, k, sent;
        fw = eff_dim(frame_width_q, MAX_WIDTH);
        fh = eff_dim(frame_height_q, MAX_HEIGHT);
        words = (fw + WORD_BITS - 1) / WORD_BITS;
        sy = int'($signed(shift_y_q));
        lo = (sy < 0) ? -sy : 0;
        hi = (sy > 0) ? fh - 1 - sy : fh - 1;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                if (lo <= hi && $urandom_range(0, 3) != 0)
                    line = $urandom_range(hi, lo);
                else
                    line = $urandom_range(0, 4095);
                len = (kind == 7) ? $urandom_range(1, words) : words;
                if (len > count - sent)
                    len = count - sent;
                for (k = 0; k < len; k++)
                begin
                    push_item(pick_word(), line, k);
                    sent++;
                end
            end
            else
            begin
                push_item(pick_word(), $urandom_range(0, 4095), $urandom_range(0, 127));
                sent++;
            end
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        src_item_t nxt;
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_gap <= 0;
        end
        else
        begin
            if (src_valid && !src_stall)
                predict_shift(src_word, src_line, src_word_index);
            if (src_valid && src_stall)
            begin
                // hold the stalled item
            end
            else if (src_gap != 0)
            begin
                src_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (src_backlog.size() != 0)
            begin
                nxt = src_backlog.pop_front();
                src_valid <= 1'b1;
                src_word <= nxt.word;
                src_line <= nxt.line;
                src_word_index <= nxt.idx;
                if ($urandom_range(0, 99) < src_idle_pct)
                    src_gap <= $urandom_range(1, 14);
            end
            else
                src_valid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        awaited_t e;
        if (!rst_n)
        begin
            dst_stall <= 1'b0;
            dst_hold <= 0;
        end
        else
        begin
            if (dst_valid && !dst_stall)
            begin
                results_seen++;
                if (awaited_words.size() == 0 || awaited_words[0].at == $time)
                begin
                    $error("unexpected item: line %0d word %0d data %h",
                           dst_line, dst_word_index, dst_word);
                    err_count++;
                end
                else
                begin
                    e = awaited_words.pop_front();
                    if (dst_word !== e.r.word)
                    begin
                        $error("dst_word: expected %h, got %h", e.r.word, dst_word);
                        err_count++;
                    end
                    if (dst_line !== e.r.line)
                    begin
                        $error("dst_line: expected %0d, got %0d", e.r.line, dst_line);
                        err_count++;
                    end
                    if (dst_word_index !== e.r.idx)
                    begin
                        $error("dst_word_index: expected %0d, got %0d", e.r.idx, dst_word_index);
                        err_count++;
                    end
                    if (run_last !== e.r.last)
                    begin
                        $error("run_last: expected %0d, got %0d", e.r.last, run_last);
                        err_count++;
                    end
                end
            end
            if (dst_hold != 0)
            begin
                dst_stall <= 1'b1;
                dst_hold <= dst_hold - 1;
            end
            else if (!pressure_done && results_seen >= 300 && src_backlog.size() > 40)
            begin
                // long hold so the pipeline backs up into the source side
                dst_stall <= 1'b1;
                dst_hold <= PRESSURE_CYCLES - 1;
                pressure_done <= 1'b1;
            end
            else if ($urandom_range(0, 99) < dst_idle_pct)
            begin
                dst_stall <= 1'b1;
                dst_hold <= $urandom_range(0, 13);
            end
            else
                dst_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (src_valid && !src_stall) || (dst_valid && !dst_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bitmap_scanline_shifter_core_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int p;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // negative unaligned shift, small frame
        configure(-37, 3, 100, 10);
        push_item(32'hFFFF_FFFF, 0, 0);
        push_item(32'h0000_0000, 0, 1);
        push_item(32'h8000_0001, 0, 2);
        push_item(32'hA5A5_A5A5, 0, 3);
        push_item(32'h1234_5678, 6, 0);
        push_item(32'hFFFF_FFFF, 6, 1);
        push_item(32'h0000_0001, 6, 2);
        push_item(32'h8000_0000, 6, 3);
        push_item(32'hDEAD_BEEF, 7, 0);
        push_item(32'hFFFF_FFFF, 10, 0);
        push_item(32'hFFFF_FFFF, 4095, 127);
        push_item(32'h5555_5555, 2, 4);
        push_item(32'hCAFE_F00D, 1, 3);
        push_item(32'h0F0F_0F0F, 1, 1);
        push_item(32'hF0F0_F0F0, 1, 2);

        // largest shifts at full frame
        configure(4095, -4095, 4096, 4096);
        push_item(32'hFFFF_FFFF, 4095, 0);
        push_item(32'h0000_0001, 4095, 1);
        configure(-4095, 4095, 4096, 4096);
        push_item(32'h8000_0000, 0, 126);
        push_item(32'hFFFF_FFFF, 0, 127);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            src_idle_pct = (p == NUM_PHASES - 1 || p % 4 == 2) ? 0 : 12;
            dst_idle_pct = (p == NUM_PHASES - 1 || p % 4 == 0) ? 0 : 12;
            fill_random(PHASE_ITEMS);
        end

        drain();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("bitmap_scanline_shifter_core_tb: PASS");
        else
            $display("bitmap_scanline_shifter_core_tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bss_pkg.sv
rtl/bss_cfg.sv
rtl/bss_in_stage.sv
rtl/bss_compute.sv
rtl/bss_out_stage.sv
rtl/bitmap_scanline_shifter_core.sv
tb/bitmap_scanline_shifter_core_tb.sv
